FILE: sv/integer_matrix_arithmetic_top_macros.svh
// assertion macros for the integer matrix arithmetic block
// used only by integer_matrix_arithmetic_top; expects clk and rst_n in scope
`ifndef INTEGER_MATRIX_ARITHMETIC_TOP_MACROS_SVH
`define INTEGER_MATRIX_ARITHMETIC_TOP_MACROS_SVH

// same-cycle implication
`define IMAT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IMAT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/imat_pkg.sv
// shared constants, control word types and microcode rom for the matrix block
// no dependencies
package imat_pkg;

  localparam int DEF_MAX_DIM    = 8;
  localparam int DEF_ELEM_WIDTH = 16;
  localparam int RESULT_W       = 35;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 4;
  localparam int CFG_OP_W   = 2;
  localparam int CFG_DIM_W  = 4;

  localparam logic [CFG_ADDR_W-1:0] REG_OPERATION    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ROW_COUNT    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_INNER_SIZE   = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_COLUMN_COUNT = 2'd3;

  localparam logic [CFG_OP_W-1:0] OP_ADD = 2'd0;
  localparam logic [CFG_OP_W-1:0] OP_SUB = 2'd1;
  localparam logic [CFG_OP_W-1:0] OP_MUL = 2'd2;

  localparam logic [CFG_DIM_W-1:0] RST_DIM = 4'd8;

  localparam int UPC_W = 3;
  localparam logic [UPC_W-1:0] UPC_IDLE  = 3'd0;
  localparam logic [UPC_W-1:0] UPC_ISSUE = 3'd1;
  localparam logic [UPC_W-1:0] UPC_WAIT1 = 3'd2;
  localparam logic [UPC_W-1:0] UPC_WAIT2 = 3'd3;
  localparam logic [UPC_W-1:0] UPC_EMIT  = 3'd4;

  localparam logic [1:0] BR_ALWAYS    = 2'd0;
  localparam logic [1:0] BR_START     = 2'd1;
  localparam logic [1:0] BR_K_LAST    = 2'd2;
  localparam logic [1:0] BR_LAST_ELEM = 2'd3;

  typedef struct packed {
    logic             issue;
    logic             emit;
    logic             wait_out;
    logic [1:0]       br_sel;
    logic [UPC_W-1:0] tgt_t;
    logic [UPC_W-1:0] tgt_f;
  } ucode_t;

  typedef struct packed {
    logic idle;
    logic issue;
    logic emit;
  } seq_ctl_t;

  typedef struct packed {
    logic k_last;
    logic last_elem;
    logic out_blocked;
    logic pipe_busy;
    logic at_origin;
  } dp_stat_t;

  function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] upc);
    ucode_t uw;
    uw = '0;
    case (upc)
      UPC_IDLE: begin
        uw.br_sel = BR_START;
        uw.tgt_t  = UPC_ISSUE;
        uw.tgt_f  = UPC_IDLE;
      end
      UPC_ISSUE: begin
        uw.issue  = 1'b1;
        uw.br_sel = BR_K_LAST;
        uw.tgt_t  = UPC_WAIT1;
        uw.tgt_f  = UPC_ISSUE;
      end
      UPC_WAIT1: begin
        uw.br_sel = BR_ALWAYS;
        uw.tgt_t  = UPC_WAIT2;
        uw.tgt_f  = UPC_WAIT2;
      end
      UPC_WAIT2: begin
        uw.br_sel = BR_ALWAYS;
        uw.tgt_t  = UPC_EMIT;
        uw.tgt_f  = UPC_EMIT;
      end
      UPC_EMIT: begin
        uw.emit     = 1'b1;
        uw.wait_out = 1'b1;
        uw.br_sel   = BR_LAST_ELEM;
        uw.tgt_t    = UPC_IDLE;
        uw.tgt_f    = UPC_ISSUE;
      end
      default: begin
        uw.br_sel = BR_ALWAYS;
        uw.tgt_t  = UPC_IDLE;
        uw.tgt_f  = UPC_IDLE;
      end
    endcase
    return uw;
  endfunction

endpackage

FILE: sv/imat_seq.sv
// microcode sequencer: step counter, control rom lookup and branch select
// depends on imat_pkg
module imat_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  imat_pkg::dp_stat_t dp_stat,
  output imat_pkg::seq_ctl_t ctl
);
  import imat_pkg::*;

  logic [UPC_W-1:0] upc_r;
  logic [UPC_W-1:0] upc_nxt;
  ucode_t           uw;
  logic             br_take;

  always_comb begin
    uw = ucode_rom(upc_r);
    case (uw.br_sel)
      BR_ALWAYS:    br_take = 1'b1;
      BR_START:     br_take = start;
      BR_K_LAST:    br_take = dp_stat.k_last;
      BR_LAST_ELEM: br_take = dp_stat.last_elem;
      default:      br_take = 1'b1;
    endcase
    if (uw.wait_out && dp_stat.out_blocked) begin
      upc_nxt = upc_r;
    end else begin
      upc_nxt = br_take ? uw.tgt_t : uw.tgt_f;
    end
    ctl.idle  = (upc_r == UPC_IDLE);
    ctl.issue = uw.issue;
    ctl.emit  = uw.emit && !dp_stat.out_blocked;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= UPC_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

FILE: sv/imat_dp.sv
// datapath: a and b element stores, index counters, multiply-accumulate pipe, result register
// depends on imat_pkg; driven by imat_seq control
module imat_dp #(
  parameter  int MAX_DIM    = imat_pkg::DEF_MAX_DIM,
  parameter  int ELEM_WIDTH = imat_pkg::DEF_ELEM_WIDTH,
  localparam int DEPTH      = MAX_DIM * MAX_DIM,
  localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int DIM_W      = $clog2(MAX_DIM + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_a_en,
  input  logic                          wr_b_en,
  input  logic [ADDR_W-1:0]             wr_addr,
  input  logic [ELEM_WIDTH-1:0]         wr_data,
  input  logic                          mul,
  input  logic                          sub,
  input  logic [DIM_W-1:0]              rows,
  input  logic [DIM_W-1:0]              inner,
  input  logic [DIM_W-1:0]              cols,
  input  imat_pkg::seq_ctl_t            ctl,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [imat_pkg::RESULT_W-1:0] out_value,
  output logic                          out_final,
  output imat_pkg::dp_stat_t            stat
);
  import imat_pkg::*;

  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int SIZE_W = $clog2(DEPTH + 1);
  localparam int WIDE_W = (2 * ELEM_WIDTH > RESULT_W) ? 2 * ELEM_WIDTH : RESULT_W;

  logic [IDX_W-1:0]  row_r, row_nxt;
  logic [IDX_W-1:0]  col_r, col_nxt;
  logic [IDX_W-1:0]  k_r, k_nxt;
  logic [DIM_W-1:0]  out_cols;
  logic              k_last, c_last, r_last;
  logic [SIZE_W-1:0] row_base, a_idx, b_idx;
  logic [ADDR_W-1:0] a_addr, b_addr;

  logic [ELEM_WIDTH-1:0] mem_a [DEPTH];
  logic [ELEM_WIDTH-1:0] mem_b [DEPTH];

  logic signed [ELEM_WIDTH-1:0]   a_rd_r, b_rd_r;
  logic                           rd_v_r, rd_first_r;
  logic                           prod_v_r, prod_first_r;
  logic signed [2*ELEM_WIDTH-1:0] mul_full;
  logic signed [WIDE_W-1:0]       mul_w, add_w, sel_w;
  logic [RESULT_W-1:0]            prod_r, acc_r, out_value_r;
  logic                           out_valid_r, out_valid_nxt, out_final_r;
  logic                           out_blocked;

  // loop bounds and element addresses
  always_comb begin
    out_cols = mul ? cols : inner;
    k_last   = mul ? ((DIM_W'(k_r) + DIM_W'(1)) == inner) : 1'b1;
    c_last   = (DIM_W'(col_r) + DIM_W'(1)) == out_cols;
    r_last   = (DIM_W'(row_r) + DIM_W'(1)) == rows;
    row_base = SIZE_W'(row_r) * SIZE_W'(inner);
    a_idx    = row_base + SIZE_W'(mul ? k_r : col_r);
    b_idx    = mul ? (SIZE_W'(k_r) * SIZE_W'(cols) + SIZE_W'(col_r)) : a_idx;
    a_addr   = a_idx[ADDR_W-1:0];
    b_addr   = b_idx[ADDR_W-1:0];
  end

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    k_nxt   = k_r;
    if (ctl.emit) begin
      k_nxt = '0;
      if (c_last) begin
        col_nxt = '0;
        row_nxt = r_last ? '0 : row_r + IDX_W'(1);
      end else begin
        col_nxt = col_r + IDX_W'(1);
      end
    end else if (ctl.issue && !k_last) begin
      k_nxt = k_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
      k_r   <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
      k_r   <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_a_en) begin
      mem_a[wr_addr] <= wr_data;
    end
    if (ctl.issue) begin
      a_rd_r <= mem_a[a_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_b_en) begin
      mem_b[wr_addr] <= wr_data;
    end
    if (ctl.issue) begin
      b_rd_r <= mem_b[b_addr];
    end
  end

  // product or element sum, then accumulate
  always_comb begin
    mul_full = a_rd_r * b_rd_r;
    mul_w    = WIDE_W'(mul_full);
    add_w    = sub ? (WIDE_W'(a_rd_r) - WIDE_W'(b_rd_r)) : (WIDE_W'(a_rd_r) + WIDE_W'(b_rd_r));
    sel_w    = mul ? mul_w : add_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r   <= 1'b0;
      prod_v_r <= 1'b0;
    end else begin
      rd_v_r   <= ctl.issue;
      prod_v_r <= rd_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      rd_first_r <= (k_r == '0);
    end
    if (rd_v_r) begin
      prod_r       <= sel_w[RESULT_W-1:0];
      prod_first_r <= rd_first_r;
    end
    if (prod_v_r) begin
      acc_r <= prod_first_r ? prod_r : acc_r + prod_r;
    end
  end

  // result register
  always_comb begin
    out_blocked   = out_valid_r && out_stall;
    out_valid_nxt = ctl.emit || out_blocked;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_value_r <= acc_r;
      out_final_r <= r_last && c_last;
    end
  end

  always_comb begin
    out_valid        = out_valid_r;
    out_value        = out_value_r;
    out_final        = out_final_r;
    stat.k_last      = k_last;
    stat.last_elem   = r_last && c_last;
    stat.out_blocked = out_blocked;
    stat.pipe_busy   = rd_v_r || prod_v_r;
    stat.at_origin   = (row_r == '0) && (col_r == '0) && (k_r == '0);
  end

endmodule

FILE: sv/integer_matrix_arithmetic_top.sv
// integer matrix add / subtract / multiply, top level with config registers and load control
// depends on imat_pkg, imat_seq, imat_dp and integer_matrix_arithmetic_top_macros.svh
//
//   channel | ports                                       | direction
//   --------+---------------------------------------------+----------
//   in      | in_valid, in_stall, in_element_value        | a then b elements
//   out     | out_valid, out_stall, out_result_value,     | result elements,
//           | out_is_final                                | row-major
//   cfg     | cfg_wr_en, cfg_index, cfg_wdata             | register writes
//
// one element beat is taken per cycle while loading; after the last b beat the
// single multiply-accumulate pipe works out one result at a time from the one read port
// on each store: issue over the inner index (once for add or subtract), then wait, emit.
// in_stall stays high from the last b beat until the last result sits in the output
// register; an output stall holds the sequencer at its emit step.
// synchronous active-low reset; stores need no clearing pass.
`include "integer_matrix_arithmetic_top_macros.svh"

module integer_matrix_arithmetic_top #(
  parameter int MAX_DIM    = imat_pkg::DEF_MAX_DIM,
  parameter int ELEM_WIDTH = imat_pkg::DEF_ELEM_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [imat_pkg::CFG_ADDR_W-1:0] cfg_index,
  input  logic [imat_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ELEM_WIDTH-1:0]           in_element_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [imat_pkg::RESULT_W-1:0]   out_result_value,
  output logic                            out_is_final
);
  import imat_pkg::*;

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int SIZE_W = $clog2(DEPTH + 1);
  localparam int TOT_W  = SIZE_W + 1;
  localparam int POS_W  = $clog2(2 * DEPTH);

  logic [CFG_OP_W-1:0]  op_r;
  logic [CFG_DIM_W-1:0] rows_r, inner_r, cols_r;
  logic [DIM_W-1:0]     rows_c, inner_c, cols_c;
  logic                 mul, sub;
  logic [SIZE_W-1:0]    a_size, b_size;
  logic [TOT_W-1:0]     total, pos_e, pos_p1, b_off;
  logic [POS_W-1:0]     pos_r;
  logic                 in_a, in_b, load_last, in_acc;
  logic [ADDR_W-1:0]    wr_addr;
  logic                 start_r, start_nxt;
  seq_ctl_t             seq_ctl;
  dp_stat_t             dp_stat;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (v > CFG_DIM_W'(MAX_DIM)) begin
      res = DIM_W'(MAX_DIM);
    end else begin
      res = v[DIM_W-1:0];
    end
    return res;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r    <= OP_MUL;
      rows_r  <= RST_DIM;
      inner_r <= RST_DIM;
      cols_r  <= RST_DIM;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_OPERATION:    op_r    <= cfg_wdata[CFG_OP_W-1:0];
        REG_ROW_COUNT:    rows_r  <= cfg_wdata[CFG_DIM_W-1:0];
        REG_INNER_SIZE:   inner_r <= cfg_wdata[CFG_DIM_W-1:0];
        REG_COLUMN_COUNT: cols_r  <= cfg_wdata[CFG_DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // matrix sizes and load placement
  always_comb begin
    rows_c    = clamp_dim(rows_r);
    inner_c   = clamp_dim(inner_r);
    cols_c    = clamp_dim(cols_r);
    mul       = (op_r != OP_ADD) && (op_r != OP_SUB);
    sub       = (op_r == OP_SUB);
    a_size    = SIZE_W'(rows_c) * SIZE_W'(inner_c);
    b_size    = mul ? (SIZE_W'(inner_c) * SIZE_W'(cols_c)) : a_size;
    total     = TOT_W'(a_size) + TOT_W'(b_size);
    pos_e     = TOT_W'(pos_r);
    pos_p1    = pos_e + TOT_W'(1);
    load_last = (pos_p1 >= total);
    in_a      = (pos_e < TOT_W'(a_size));
    b_off     = pos_e - TOT_W'(a_size);
    in_b      = !in_a && (b_off < TOT_W'(b_size));
    wr_addr   = in_a ? pos_e[ADDR_W-1:0] : b_off[ADDR_W-1:0];
    in_stall  = !seq_ctl.idle || start_r;
    in_acc    = in_valid && !in_stall;
    start_nxt = (in_acc && load_last) || (start_r && !seq_ctl.idle);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      start_r <= 1'b0;
    end else begin
      start_r <= start_nxt;
      if (in_acc) begin
        pos_r <= load_last ? '0 : pos_p1[POS_W-1:0];
      end
    end
  end

  imat_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start_r),
    .dp_stat (dp_stat),
    .ctl     (seq_ctl)
  );

  imat_dp #(
    .MAX_DIM    (MAX_DIM),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_a_en   (in_acc && in_a),
    .wr_b_en   (in_acc && in_b),
    .wr_addr   (wr_addr),
    .wr_data   (in_element_value),
    .mul       (mul),
    .sub       (sub),
    .rows      (rows_c),
    .inner     (inner_c),
    .cols      (cols_c),
    .ctl       (seq_ctl),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_value (out_result_value),
    .out_final (out_is_final),
    .stat      (dp_stat)
  );

  `IMAT_ASSERT_IMP(a_emit_drained, seq_ctl.emit, !dp_stat.pipe_busy, "result taken before accumulation drained")
  `IMAT_ASSERT_IMP(a_idle_origin, seq_ctl.idle, dp_stat.at_origin, "sequencer idle with loop indices not cleared")
  `IMAT_ASSERT_NXT(a_last_busy, in_acc && load_last, in_stall, "input not held off after the last element beat")

endmodule

FILE: verif/tb_integer_matrix_arithmetic_top.sv
`timescale 1ns / 1ps
// testbench for integer_matrix_arithmetic_top: directed and random matrix loads, checked
// beat by beat against an in-bench predictor of add, subtract and multiply results
// depends on imat_pkg and the integer_matrix_arithmetic_top rtl
module tb_integer_matrix_arithmetic_top;
  import imat_pkg::*;

  localparam int MAX_DIM = DEF_MAX_DIM;
  localparam int ELEM_W = DEF_ELEM_WIDTH;
  localparam int SETTLE_CYCLES = 16;
  localparam int TOTAL_ITEMS = 420;
  localparam int LONG_HOLD = 400;
  localparam logic [CFG_OP_W-1:0] OP_MUL_ALIAS = 2'd3;

  typedef struct packed {
    logic [RESULT_W-1:0] value;
    logic last;
  } result_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [ELEM_W-1:0] in_element_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [RESULT_W-1:0] out_result_value;
  logic out_is_final;

  // predictor state
  logic [CFG_OP_W-1:0] op_reg = OP_MUL;
  logic [CFG_DIM_W-1:0] rows_reg = RST_DIM;
  logic [CFG_DIM_W-1:0] inner_reg = RST_DIM;
  logic [CFG_DIM_W-1:0] cols_reg = RST_DIM;
  logic signed [ELEM_W-1:0] a_mem [MAX_DIM*MAX_DIM];
  logic signed [ELEM_W-1:0] b_mem [MAX_DIM*MAX_DIM];
  int unsigned load_pos = 0;
  result_beat_t expected_results[$];

  int idle_pct = 6;
  int stall_pct = 6;
  int hold_cycles = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int items_sent = 0;
  int mismatch_count = 0;

  integer_matrix_arithmetic_top u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_element_value(in_element_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_result_value(out_result_value),
    .out_is_final(out_is_final)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int unsigned dim_of(input logic [CFG_DIM_W-1:0] r);
    if (r == 0) return 1;
    if (r > MAX_DIM) return MAX_DIM;
    return r;
  endfunction

  function automatic int unsigned load_length();
    int unsigned a_size;
    a_size = dim_of(rows_reg) * dim_of(inner_reg);
    if (op_reg == OP_MUL || op_reg == OP_MUL_ALIAS)
      return a_size + dim_of(inner_reg) * dim_of(cols_reg);
    return 2 * a_size;
  endfunction

  // stores one element and, on the last one, queues the whole result matrix
  function automatic void apply_element(input logic [ELEM_W-1:0] v);
    int unsigned rows, inner, cols, a_size, b_size, total, out_cols;
    int unsigned r, c, k, e;
    logic mul;
    longint acc;
    result_beat_t rb;
    rows = dim_of(rows_reg);
    inner = dim_of(inner_reg);
    cols = dim_of(cols_reg);
    mul = (op_reg == OP_MUL) || (op_reg == OP_MUL_ALIAS);
    a_size = rows * inner;
    b_size = mul ? inner * cols : a_size;
    total = a_size + b_size;
    out_cols = mul ? cols : inner;
    if (load_pos < a_size) a_mem[load_pos] = v;
    else if (load_pos - a_size < b_size) b_mem[load_pos - a_size] = v;
    if (load_pos + 1 < total) begin
      load_pos++;
      return;
    end
    for (r = 0; r < rows; r++) begin
      for (c = 0; c < out_cols; c++) begin
        if (mul) begin
          acc = 0;
          for (k = 0; k < inner; k++)
            acc += longint'(a_mem[r*inner + k]) * longint'(b_mem[k*cols + c]);
        end else begin
          e = r*inner + c;
          if (op_reg == OP_ADD) acc = longint'(a_mem[e]) + longint'(b_mem[e]);
          else acc = longint'(a_mem[e]) - longint'(b_mem[e]);
        end
        rb.value = acc[RESULT_W-1:0];
        rb.last = (r == rows - 1) && (c == out_cols - 1);
        expected_results.push_back(rb);
      end
    end
    load_pos = 0;
  endfunction

  function automatic logic [ELEM_W-1:0] pick_element(input int extreme_pct);
    if ($urandom_range(0, 99) < extreme_pct) begin
      case ($urandom_range(0, 3))
        0: return 16'h8000;
        1: return 16'h7fff;
        2: return 16'h0000;
        default: return 16'hffff;
      endcase
    end
    return ELEM_W'($urandom);
  endfunction

  function automatic logic [CFG_DIM_W-1:0] pick_dim();
    if ($urandom_range(0, 99) < 80) return CFG_DIM_W'($urandom_range(1, 3));
    return CFG_DIM_W'($urandom_range(0, 15));
  endfunction

  task automatic send_element(input logic [ELEM_W-1:0] v);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      in_element_value <= ELEM_W'($urandom);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_element_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_element(v);
    items_sent++;
  endtask

  task automatic send_matrix(input int extreme_pct);
    int unsigned n;
    n = load_length();
    repeat (n) send_element(pick_element(extreme_pct));
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_OPERATION: op_reg = data[CFG_OP_W-1:0];
      REG_ROW_COUNT: rows_reg = data;
      REG_INNER_SIZE: inner_reg = data;
      default: cols_reg = data;
    endcase
  endtask

  task automatic configure(input logic [CFG_OP_W-1:0] op, input logic [CFG_DIM_W-1:0] r,
                           input logic [CFG_DIM_W-1:0] i, input logic [CFG_DIM_W-1:0] c);
    write_reg(REG_OPERATION, CFG_DATA_W'(op));
    write_reg(REG_ROW_COUNT, r);
    write_reg(REG_INNER_SIZE, i);
    write_reg(REG_COLUMN_COUNT, c);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic test_add_extremes();
    configure(OP_ADD, 4'd1, 4'd2, 4'd5);
    send_element(16'h7fff);
    send_element(16'h8000);
    send_element(16'h7fff);
    send_element(16'h8000);
    drain_results();
  endtask

  task automatic test_sub_zero_dims();
    configure(OP_SUB, 4'd0, 4'd2, 4'd0);
    send_element(16'h8000);
    send_element(16'h7fff);
    send_element(16'h7fff);
    send_element(16'h8000);
    drain_results();
  endtask

  task automatic test_unused_op_code();
    configure(OP_MUL_ALIAS, 4'd1, 4'd2, 4'd1);
    repeat (4) send_element(16'h8000);
    drain_results();
  endtask

  task automatic test_oversize_dims();
    configure(OP_MUL, 4'd15, 4'd0, 4'd0);
    send_matrix(50);
    drain_results();
  endtask

  // shrink the sizes below the load position so the next beat ends the load
  task automatic test_midload_resize();
    configure(OP_MUL, 4'd1, 4'd2, 4'd1);
    send_element(16'hffff);
    send_element(16'h1234);
    send_element(16'h7fff);
    drain_results();
    configure(OP_MUL, 4'd1, 4'd0, 4'd1);
    send_element(16'h0001);
    drain_results();
  endtask

  task automatic test_full_size();
    configure(OP_MUL, 4'd8, 4'd8, 4'd8);
    send_matrix(90);
    drain_results();
    configure(OP_ADD, 4'd8, 4'd8, 4'd1);
    send_matrix(90);
    drain_results();
  endtask

  task automatic test_output_backpressure();
    configure(OP_MUL, 4'd2, 4'd2, 4'd2);
    hold_cycles = LONG_HOLD;
    hold_seq++;
    repeat (3) send_matrix(20);
    drain_results();
  endtask

  task automatic test_no_idle_stretch();
    idle_pct = 0;
    stall_pct = 0;
    configure(OP_SUB, 4'd3, 4'd3, 4'd3);
    repeat (3) send_matrix(20);
    drain_results();
    configure(OP_MUL, 4'd3, 4'd2, 4'd3);
    repeat (3) send_matrix(20);
    drain_results();
    idle_pct = 6;
    stall_pct = 6;
  endtask

  task automatic test_random_matrices();
    int goal;
    goal = TOTAL_ITEMS;
    while (items_sent < goal) begin
      configure(CFG_OP_W'($urandom_range(0, 3)), pick_dim(), pick_dim(), pick_dim());
      repeat ($urandom_range(1, 4)) send_matrix(20);
      drain_results();
    end
  endtask

  // receiver stall, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = hold_cycles;
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    result_beat_t exp_beat;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected result beat at %0t: value %0d final %0b", $realtime,
                   $signed(out_result_value), out_is_final);
        mismatch_count++;
      end else begin
        exp_beat = expected_results.pop_front();
        if (out_result_value !== exp_beat.value || out_is_final !== exp_beat.last) begin
          if (mismatch_count < 10)
            $display("mismatch at %0t: expected value %0d final %0b, got value %0d final %0b",
                     $realtime, $signed(exp_beat.value), exp_beat.last,
                     $signed(out_result_value), out_is_final);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (4) @(posedge clk);
    test_add_extremes();
    test_sub_zero_dims();
    test_unused_op_code();
    test_oversize_dims();
    test_midload_resize();
    test_full_size();
    test_output_backpressure();
    test_no_idle_stretch();
    test_random_matrices();
    drain_results();
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/imat_pkg.sv
sv/imat_seq.sv
sv/imat_dp.sv
sv/integer_matrix_arithmetic_top.sv
verif/tb_integer_matrix_arithmetic_top.sv
